// ===== hdl/qte_pkg.sv =====
`default_nettype none
package qte_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int FRAC_BITS_DEF     = 14;
   localparam int ATAN_TAB_LEN      = 24;
   localparam int IN_W              = 16;
   localparam int IN_FRAC           = 14;
   localparam int PROD_W            = 32;
   localparam int SUM_W             = 34;
   localparam int ANG_FRAC          = 16;
   localparam int ANG_W             = 27;
   localparam int QUO_W             = 11;
   localparam int STEP_W            = 7;
   localparam int STEP_RESET        = 5;
   localparam int HALF_TURN_DEG     = 180;
   localparam int PITCH_W           = 9;
   localparam int YAW_W             = 8;
   localparam int ROLL_W            = 9;
   localparam int LANES             = 3;
   localparam int LANE_PITCH        = 0;
   localparam int LANE_YAW          = 1;
   localparam int LANE_ROLL         = 2;

   // atan(2^-i) in units of 2^-16 degree, rounded to nearest
   function automatic logic [ANG_W-1:0] atan_tab(input int idx);
      logic [ANG_W-1:0] v;
      case (idx)
         0:  v = ANG_W'(2949120);
         1:  v = ANG_W'(1740967);
         2:  v = ANG_W'(919879);
         3:  v = ANG_W'(466945);
         4:  v = ANG_W'(234379);
         5:  v = ANG_W'(117304);
         6:  v = ANG_W'(58666);
         7:  v = ANG_W'(29335);
         8:  v = ANG_W'(14668);
         9:  v = ANG_W'(7334);
         10: v = ANG_W'(3667);
         11: v = ANG_W'(1833);
         12: v = ANG_W'(917);
         13: v = ANG_W'(458);
         14: v = ANG_W'(229);
         15: v = ANG_W'(115);
         16: v = ANG_W'(57);
         17: v = ANG_W'(29);
         18: v = ANG_W'(14);
         19: v = ANG_W'(7);
         20: v = ANG_W'(4);
         21: v = ANG_W'(2);
         22: v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/qte_sqrt_cell.sv =====
`default_nettype none
module qte_sqrt_cell #(
   parameter int RAD_W   = 29,
   parameter int BIT_POS = 28,
   parameter int SIDE_W  = 96
) (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [RAD_W-1:0]  rem_i,
   input  wire logic [RAD_W:0]    res_i,
   input  wire logic [SIDE_W-1:0] side_i,
   output logic      [RAD_W-1:0]  rem_o,
   output logic      [RAD_W:0]    res_o,
   output logic      [SIDE_W-1:0] side_o
);
   localparam logic [RAD_W:0] BIT_VAL = (RAD_W+1)'(1) << BIT_POS;

   logic [RAD_W-1:0]  rem_ff, rem_in;
   logic [RAD_W:0]    res_ff, res_in, trial;
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      trial = res_i + BIT_VAL;
      if ({1'b0, rem_i} >= trial) begin
         rem_in = rem_i - trial[RAD_W-1:0];
         res_in = (res_i >> 1) + BIT_VAL;
      end else begin
         rem_in = rem_i;
         res_in = res_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         res_ff  <= res_in;
         side_ff <= side_i;
      end
   end

   assign rem_o  = rem_ff;
   assign res_o  = res_ff;
   assign side_o = side_ff;
endmodule
`default_nettype wire

// ===== hdl/qte_cordic_cell.sv =====
`default_nettype none
module qte_cordic_cell #(
   parameter int CW    = 23,
   parameter int STAGE = 0
) (
   input  wire logic                            clock,
   input  wire logic                            enable,
   input  wire logic signed [CW-1:0]            x_i,
   input  wire logic signed [CW-1:0]            y_i,
   input  wire logic signed [qte_pkg::ANG_W-1:0] z_i,
   input  wire logic                            zero_i,
   output logic      signed [CW-1:0]            x_o,
   output logic      signed [CW-1:0]            y_o,
   output logic      signed [qte_pkg::ANG_W-1:0] z_o,
   output logic                                 zero_o
);
   import qte_pkg::*;

   localparam logic signed [ANG_W-1:0] ATAN_VAL = atan_tab(STAGE);

   logic signed [CW-1:0]    x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic                    zero_ff;

   always_comb begin
      xs = x_i >>> STAGE;
      ys = y_i >>> STAGE;
      // rotate clockwise while y is non-negative
      if (!y_i[CW-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ATAN_VAL;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ATAN_VAL;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= zero_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign zero_o = zero_ff;
endmodule
`default_nettype wire

// ===== hdl/qte_div_cell.sv =====
`default_nettype none
module qte_div_cell #(
   parameter int BIT_IDX = 10
) (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [qte_pkg::STEP_W-1:0]   step_i,
   input  wire logic [qte_pkg::QUO_W-1:0]    num_i,
   input  wire logic [qte_pkg::STEP_W-1:0]   rem_i,
   input  wire logic [qte_pkg::QUO_W-1:0]    quo_i,
   input  wire logic                         neg_i,
   output logic      [qte_pkg::QUO_W-1:0]    num_o,
   output logic      [qte_pkg::STEP_W-1:0]   rem_o,
   output logic      [qte_pkg::QUO_W-1:0]    quo_o,
   output logic                              neg_o
);
   import qte_pkg::*;

   logic [STEP_W:0]   trial;
   logic [STEP_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in, num_ff;
   logic              neg_ff;

   always_comb begin
      trial  = {rem_i, num_i[BIT_IDX]};
      quo_in = quo_i;
      if (trial >= {1'b0, step_i}) begin
         rem_in          = STEP_W'(trial - {1'b0, step_i});
         quo_in[BIT_IDX] = 1'b1;
      end else begin
         rem_in = trial[STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         num_ff <= num_i;
         neg_ff <= neg_i;
      end
   end

   assign num_o = num_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign neg_o = neg_ff;
endmodule
`default_nettype wire

// ===== hdl/quaternion_to_euler_quantized_top.sv =====
// Quaternion to Euler angles, each rounded to a multiple of a programmable step.
// Input channel req_*: one quaternion (x, y, z, w), signed Q1.14, per beat.
// Output channel rsp_*: pitch, yaw and roll in whole degrees, one beat per input.
// csr_wr_en / csr_wr_data load the step in degrees (reset value 5, zero acts as 1);
// write it only while the pipeline is empty.
// Throughput: one beat per cycle unless the receiver stalls. The data path is a
// chain of registered cells: products, sums, radicand, FRAC_BITS+1 square-root
// cells, a prep stage, CORDIC_STAGES rotation cells per angle (at most ATAN_TAB_LEN),
// a magnitude stage, 11 divider cells and the output register.
// Reset empties the pipeline and restores the step. When the receiver stalls,
// the whole chain holds, req_ready drops, and the result stays on rsp_*.
`default_nettype none
module quaternion_to_euler_quantized_top #(
   parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
   parameter int FRAC_BITS     = qte_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [qte_pkg::IN_W-1:0]     req_quat_x,
   input  wire logic signed [qte_pkg::IN_W-1:0]     req_quat_y,
   input  wire logic signed [qte_pkg::IN_W-1:0]     req_quat_z,
   input  wire logic signed [qte_pkg::IN_W-1:0]     req_quat_w,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      signed [qte_pkg::PITCH_W-1:0]  rsp_pitch_deg,
   output logic      signed [qte_pkg::YAW_W-1:0]    rsp_yaw_deg,
   output logic      signed [qte_pkg::ROLL_W-1:0]   rsp_roll_deg,
   input  wire logic                                csr_wr_en,
   input  wire logic [qte_pkg::STEP_W-1:0]          csr_wr_data
);
   import qte_pkg::*;

   localparam int NST   = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
   localparam int SH    = 2 * IN_FRAC - FRAC_BITS;
   localparam int OW    = SUM_W - SH;
   localparam int SW    = FRAC_BITS + 2;
   localparam int PW    = 2 * SW;
   localparam int RW    = 2 * FRAC_BITS + 1;
   localparam int CW    = OW + 3;
   localparam int SIDE  = 4 * OW + SW;
   localparam int NSQ   = FRAC_BITS + 1;
   localparam int LAT   = NSQ + NST + QUO_W + 6;
   localparam logic signed [OW-1:0]    ONE_R  = OW'(1) << FRAC_BITS;
   localparam logic signed [OW-1:0]    MONE_R = -ONE_R;
   localparam logic signed [ANG_W-1:0] HALF_T = ANG_W'(HALF_TURN_DEG) << ANG_FRAC;

   logic enable;
   logic [LAT-1:0] valid_ff, valid_in;
   logic [STEP_W-1:0] angle_step_ff, step_eff;

   assign enable    = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = valid_ff[LAT-1];
   assign step_eff  = (angle_step_ff == '0) ? STEP_W'(1) : angle_step_ff;
   assign valid_in  = {valid_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         angle_step_ff <= STEP_W'(STEP_RESET);
      end else begin
         if (enable) valid_ff <= valid_in;
         if (csr_wr_en) angle_step_ff <= csr_wr_data;
      end
   end

   // products
   logic signed [PROD_W-1:0] yz_ff, wx_ff, ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PROD_W-1:0] xy_ff, wz_ff, wy_ff, xz_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         yz_ff <= PROD_W'(req_quat_y) * PROD_W'(req_quat_z);
         wx_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_x);
         ww_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_w);
         xx_ff <= PROD_W'(req_quat_x) * PROD_W'(req_quat_x);
         yy_ff <= PROD_W'(req_quat_y) * PROD_W'(req_quat_y);
         zz_ff <= PROD_W'(req_quat_z) * PROD_W'(req_quat_z);
         xy_ff <= PROD_W'(req_quat_x) * PROD_W'(req_quat_y);
         wz_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_z);
         wy_ff <= PROD_W'(req_quat_w) * PROD_W'(req_quat_y);
         xz_ff <= PROD_W'(req_quat_x) * PROD_W'(req_quat_z);
      end
   end

   // sums, floor shift to FRAC_BITS, saturate the asin argument
   logic signed [SUM_W-1:0] pa_sum, pb_sum, ra_sum, rb_sum, s_sum;
   logic signed [OW-1:0]    pa_in, pb_in, ra_in, rb_in, s_red;
   logic signed [OW-1:0]    pa_ff, pb_ff, ra_ff, rb_ff;
   logic signed [SW-1:0]    s_in, s_ff;

   always_comb begin
      pa_sum = (SUM_W'(yz_ff) + SUM_W'(wx_ff)) <<< 1;
      pb_sum = SUM_W'(ww_ff) - SUM_W'(xx_ff) - SUM_W'(yy_ff) + SUM_W'(zz_ff);
      ra_sum = (SUM_W'(xy_ff) + SUM_W'(wz_ff)) <<< 1;
      rb_sum = SUM_W'(ww_ff) + SUM_W'(xx_ff) - SUM_W'(yy_ff) - SUM_W'(zz_ff);
      s_sum  = (SUM_W'(wy_ff) - SUM_W'(xz_ff)) <<< 1;
      pa_in  = OW'(pa_sum >>> SH);
      pb_in  = OW'(pb_sum >>> SH);
      ra_in  = OW'(ra_sum >>> SH);
      rb_in  = OW'(rb_sum >>> SH);
      s_red  = OW'(s_sum >>> SH);
      if (s_red > ONE_R)       s_in = SW'(ONE_R);
      else if (s_red < MONE_R) s_in = SW'(MONE_R);
      else                     s_in = SW'(s_red);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         ra_ff <= ra_in;
         rb_ff <= rb_in;
         s_ff  <= s_in;
      end
   end

   // radicand 1 - s*s
   logic signed [PW-1:0] ss;
   logic [RW-1:0]        rad_ff;
   logic [SIDE-1:0]      side_ff;

   assign ss = PW'(s_ff) * PW'(s_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= RW'((PW'(1) <<< (2 * FRAC_BITS)) - ss);
         side_ff <= {pa_ff, pb_ff, ra_ff, rb_ff, s_ff};
      end
   end

   // square-root chain, one result bit per cell
   logic [RW-1:0]   sq_rem  [NSQ+1];
   logic [RW:0]     sq_res  [NSQ+1];
   logic [SIDE-1:0] sq_side [NSQ+1];

   assign sq_rem[0]  = rad_ff;
   assign sq_res[0]  = '0;
   assign sq_side[0] = side_ff;

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      qte_sqrt_cell #(
         .RAD_W  (RW),
         .BIT_POS(2 * (FRAC_BITS - k)),
         .SIDE_W (SIDE)
      ) u_cell (
         .clock (clock),
         .enable(enable),
         .rem_i (sq_rem[k]),
         .res_i (sq_res[k]),
         .side_i(sq_side[k]),
         .rem_o (sq_rem[k+1]),
         .res_o (sq_res[k+1]),
         .side_o(sq_side[k+1])
      );
   end

   // CORDIC entry: left half plane fold, zero vector flag
   logic signed [OW-1:0] d_pa, d_pb, d_ra, d_rb;
   logic signed [SW-1:0] d_s;
   logic signed [CW-1:0] ent_x [LANES];
   logic signed [CW-1:0] ent_y [LANES];

   assign {d_pa, d_pb, d_ra, d_rb, d_s} = sq_side[NSQ];
   assign ent_x[LANE_PITCH] = CW'(d_pb);
   assign ent_y[LANE_PITCH] = CW'(d_pa);
   assign ent_x[LANE_YAW]   = CW'(sq_res[NSQ][FRAC_BITS:0]);
   assign ent_y[LANE_YAW]   = CW'(d_s);
   assign ent_x[LANE_ROLL]  = CW'(d_rb);
   assign ent_y[LANE_ROLL]  = CW'(d_ra);

   logic signed [CW-1:0]    cx [LANES][NST+1];
   logic signed [CW-1:0]    cy [LANES][NST+1];
   logic signed [ANG_W-1:0] cz [LANES][NST+1];
   logic                    cn [LANES][NST+1];

   logic [QUO_W-1:0]  dn [LANES][QUO_W+1];
   logic [STEP_W-1:0] dr [LANES][QUO_W+1];
   logic [QUO_W-1:0]  dq [LANES][QUO_W+1];
   logic              dg [LANES][QUO_W+1];

   logic [QUO_W+STEP_W-1:0] prod [LANES];
   logic [QUO_W+STEP_W-1:0] sval [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [CW-1:0]    px_ff, py_ff;
      logic signed [ANG_W-1:0] pz_ff;
      logic                    pn_ff;
      logic signed [ANG_W-1:0] zf;
      logic [ANG_W-1:0]        mag;
      logic [ANG_W:0]          biased;
      logic [QUO_W-1:0]        num_ff;
      logic                    neg_ff;

      always_ff @(posedge clock) begin
         if (enable) begin
            pn_ff <= (ent_x[l] == '0) && (ent_y[l] == '0);
            if (ent_x[l][CW-1]) begin
               px_ff <= -ent_x[l];
               py_ff <= -ent_y[l];
               pz_ff <= ent_y[l][CW-1] ? -HALF_T : HALF_T;
            end else begin
               px_ff <= ent_x[l];
               py_ff <= ent_y[l];
               pz_ff <= '0;
            end
         end
      end

      assign cx[l][0] = px_ff;
      assign cy[l][0] = py_ff;
      assign cz[l][0] = pz_ff;
      assign cn[l][0] = pn_ff;

      for (genvar i = 0; i < NST; i++) begin : g_rot
         qte_cordic_cell #(.CW(CW), .STAGE(i)) u_cell (
            .clock (clock),
            .enable(enable),
            .x_i   (cx[l][i]),
            .y_i   (cy[l][i]),
            .z_i   (cz[l][i]),
            .zero_i(cn[l][i]),
            .x_o   (cx[l][i+1]),
            .y_o   (cy[l][i+1]),
            .z_o   (cz[l][i+1]),
            .zero_o(cn[l][i+1])
         );
      end

      // magnitude plus half a step, in whole degrees
      always_comb begin
         zf     = cn[l][NST] ? '0 : cz[l][NST];
         mag    = zf[ANG_W-1] ? ANG_W'(-zf) : ANG_W'(zf);
         biased = (ANG_W+1)'(mag) + ((ANG_W+1)'(step_eff) << (ANG_FRAC - 1));
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff <= QUO_W'(biased >> ANG_FRAC);
            neg_ff <= zf[ANG_W-1];
         end
      end

      assign dn[l][0] = num_ff;
      assign dr[l][0] = '0;
      assign dq[l][0] = '0;
      assign dg[l][0] = neg_ff;

      for (genvar b = 0; b < QUO_W; b++) begin : g_div
         qte_div_cell #(.BIT_IDX(QUO_W - 1 - b)) u_cell (
            .clock (clock),
            .enable(enable),
            .step_i(step_eff),
            .num_i (dn[l][b]),
            .rem_i (dr[l][b]),
            .quo_i (dq[l][b]),
            .neg_i (dg[l][b]),
            .num_o (dn[l][b+1]),
            .rem_o (dr[l][b+1]),
            .quo_o (dq[l][b+1]),
            .neg_o (dg[l][b+1])
         );
      end

      assign prod[l] = (QUO_W+STEP_W)'(dq[l][QUO_W]) * (QUO_W+STEP_W)'(step_eff);
      assign sval[l] = dg[l][QUO_W] ? -prod[l] : prod[l];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_pitch_deg <= PITCH_W'(sval[LANE_PITCH]);
         rsp_yaw_deg   <= YAW_W'(sval[LANE_YAW]);
         rsp_roll_deg  <= ROLL_W'(sval[LANE_ROLL]);
      end
   end

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(valid_ff) && rsp_valid)
      else $error("pipeline advanced during output stall");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && (angle_step_ff == STEP_W'(STEP_RESET)))
      else $error("pipeline not empty after reset");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> angle_step_ff == $past(csr_wr_data))
      else $error("step register missed a write");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[LAT-2] && rsp_ready |=> !rsp_valid)
      else $error("result beat from an empty stage");
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import qte_pkg::*;

   localparam int LATENCY = FRAC_BITS_DEF + CORDIC_STAGES_DEF + 18;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
      logic signed [ROLL_W-1:0]  roll;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_W-1:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [PITCH_W-1:0] rsp_pitch_deg;
   logic signed [YAW_W-1:0]   rsp_yaw_deg;
   logic signed [ROLL_W-1:0]  rsp_roll_deg;
   logic csr_wr_en = 1'b0;
   logic [STEP_W-1:0] csr_wr_data = '0;

   quaternion_to_euler_quantized_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_quat_x(req_quat_x), .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z), .req_quat_w(req_quat_w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pitch_deg(rsp_pitch_deg), .rsp_yaw_deg(rsp_yaw_deg),
      .rsp_roll_deg(rsp_roll_deg),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   euler_type expected_angles[$];
   int unsigned mismatches = 0;
   longint cycle_count = 0;
   logic [STEP_W-1:0] step_deg = STEP_W'(STEP_RESET);
   bit rsp_stall_on = 1'b1;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
   endtask

   function automatic longint floor_shr(input longint v, input int s);
      return v >>> s;
   endfunction

   // vectoring CORDIC, result in 2^-16 degree
   function automatic longint cordic_atan2(input longint y, input longint x);
      longint ang, xs, ys;
      longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         ang = (y >= 0) ? (longint'(180) <<< ANG_FRAC) : -(longint'(180) <<< ANG_FRAC);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; ang += tab[i];
         end else begin
            x -= ys; y += xs; ang -= tab[i];
         end
      end
      return ang;
   endfunction

   function automatic longint isqrt(input longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic longint snap_to_step(input longint ang, input longint step);
      longint mag, unit, q;
      if (step == 0) step = 1;
      mag = ang < 0 ? -ang : ang;
      unit = step <<< ANG_FRAC;
      q = ((mag + (unit >>> 1)) / unit) * step;
      return ang > 0 ? q : -q;
   endfunction

   function automatic euler_type predict_angles(input logic signed [IN_W-1:0] qx, qy, qz, qw);
      longint x, y, z, w, pa, pb, ra, rb, s, c, one;
      int sh;
      euler_type r;
      x = qx; y = qy; z = qz; w = qw;
      sh = 2 * IN_FRAC - FRAC_BITS_DEF;
      one = longint'(1) <<< FRAC_BITS_DEF;
      pa = floor_shr(2 * (y * z + w * x), sh);
      pb = floor_shr(w * w - x * x - y * y + z * z, sh);
      ra = floor_shr(2 * (x * y + w * z), sh);
      rb = floor_shr(w * w + x * x - y * y - z * z, sh);
      s = floor_shr(2 * (w * y - x * z), sh);
      if (s > one) s = one;
      if (s < -one) s = -one;
      c = isqrt(one * one - s * s);
      r.pitch = PITCH_W'(snap_to_step(cordic_atan2(pa, pb), step_deg));
      r.yaw   = YAW_W'(snap_to_step(cordic_atan2(s, c), step_deg));
      r.roll  = ROLL_W'(snap_to_step(cordic_atan2(ra, rb), step_deg));
      return r;
   endfunction

   function automatic int pick_gap();
      int roll_pct;
      roll_pct = $urandom_range(0, 99);
      if (roll_pct < 55) return 0;
      if (roll_pct < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_angles.size() == 0) begin
            report("unexpected beat", 0, 0);
         end else begin
            euler_type e;
            e = expected_angles.pop_front();
            if (rsp_pitch_deg !== e.pitch) report("pitch", rsp_pitch_deg, e.pitch);
            if (rsp_yaw_deg !== e.yaw) report("yaw", rsp_yaw_deg, e.yaw);
            if (rsp_roll_deg !== e.roll) report("roll", rsp_roll_deg, e.roll);
         end
      end
   end

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = rsp_stall_on ? pick_gap() : 0;
         rsp_ready <= (gap == 0);
         @(negedge clock);
         repeat (gap > 0 ? gap - 1 : 0) @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   bit send_gaps_on = 1'b1;

   // valid stays high into the next beat unless a gap drops it
   task automatic send_quat(input logic signed [IN_W-1:0] qx, qy, qz, qw);
      int gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_quat_x <= qx; req_quat_y <= qy; req_quat_z <= qz; req_quat_w <= qw;
      expected_angles.push_back(predict_angles(qx, qy, qz, qw));
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_and_set_step(input logic [STEP_W-1:0] v);
      req_valid <= 1'b0;
      wait (expected_angles.size() == 0);
      repeat (LATENCY + 4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      step_deg = v;
   endtask

   function automatic logic signed [IN_W-1:0] rand_comp();
      return IN_W'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic test_directed();
      logic signed [IN_W-1:0] ex[9] = '{16384, -16384, 0, 11585, -11585, 16383, -1, 1, -32768};
      send_quat(0, 0, 0, 16384);           // identity
      send_quat(0, 0, 0, 0);               // zero vector in the pitch and roll atan2
      send_quat(16384, 0, 0, 0);           // 180 about x, left half plane
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 11585, 0, 11585);       // gimbal lock, yaw +90
      send_quat(0, -11585, 0, 11585);      // yaw -90
      send_quat(16384, 16384, -16384, 16384); // asin saturates
      send_quat(-32768, -32768, -32768, -32768); // beyond +-1.0
      send_quat(32767, 32767, 32767, 32767);
      send_quat(-16384, 1, 0, -1);         // pitch near +180
      send_quat(-16384, -1, 0, -1);
      for (int i = 0; i < 9; i++)
         send_quat(ex[i], ex[(i + 3) % 9], ex[(i + 5) % 9], ex[(i + 7) % 9]);
   endtask

   task automatic test_random(input int count);
      int mode;
      logic signed [IN_W-1:0] qx, qy, qz, qw;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 7) begin
            qx = rand_comp(); qy = rand_comp(); qz = rand_comp(); qw = rand_comp();
         end else if (mode < 9) begin
            // near a pole of yaw
            qw = IN_W'($urandom_range(11000, 12200));
            qy = ($urandom_range(0, 1) ? qw : -qw) + IN_W'($signed($urandom_range(0, 200)) - 100);
            qx = IN_W'($signed($urandom_range(0, 400)) - 200);
            qz = IN_W'($signed($urandom_range(0, 400)) - 200);
         end else begin
            qx = IN_W'($urandom); qy = IN_W'($urandom);
            qz = IN_W'($urandom); qw = IN_W'($urandom);
         end
         send_quat(qx, qy, qz, qw);
      end
   endtask

   task automatic test_back_to_back(input int count);
      send_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      test_random(count);
      send_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain_and_set_step(1);
      test_directed();
      test_random(200);
      drain_and_set_step(90);
      test_random(150);
      drain_and_set_step(0);
      test_random(150);
      drain_and_set_step(127);
      test_directed();
      test_random(100);
      drain_and_set_step(7);
      test_back_to_back(150);
      drain_and_set_step(45);
      test_random(237);
      req_valid <= 1'b0;
      wait (expected_angles.size() == 0);
      repeat (LATENCY + 10) @(negedge clock);
      if (mismatches == 0 && expected_angles.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
